[rtl/tcf_pkg.sv]
// Shared types, constants, codes and the quarter-sine table for the crossfade envelope.
package tcf_pkg;

  localparam int TIME_BITS    = 16;
  localparam int VOLUME_BITS  = 16;
  localparam int SINE_ENTRIES = 256;
  localparam int GAIN_FRAC    = 16;
  localparam int GAIN_W       = GAIN_FRAC + 1;
  localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES + 1);
  localparam int SINE_POS_W   = GAIN_W + SINE_IDX_W;
  localparam int DIV_CNT_W    = $clog2(GAIN_FRAC);
  localparam int MUL_W        = 18;

  localparam logic [GAIN_W-1:0]      GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [GAIN_W-1:0]      GAIN_HALF = GAIN_W'(1) << (GAIN_FRAC - 1);
  localparam logic [VOLUME_BITS-1:0] VOL_ONE   = VOLUME_BITS'(1) << (VOLUME_BITS - 1);
  localparam logic [MUL_W-1:0]       SMOOTH_K  = MUL_W'(3) << GAIN_FRAC;
  localparam longint unsigned        HALF_PI_Q30 = 64'd1686629713;

  // Taylor series divisors (2k)*(2k+1) for k = 1..7
  localparam longint unsigned TAYLOR_DEN [1:7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  // Commands
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;
  localparam logic [1:0] CMD_RESET  = 2'd3;

  // Player actions
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_SET_OUT  = 3'd1;
  localparam logic [2:0] ACT_SET_IN   = 3'd2;
  localparam logic [2:0] ACT_STOP_OUT = 3'd3;
  localparam logic [2:0] ACT_PLAY_IN  = 3'd4;
  localparam logic [2:0] ACT_STATE    = 3'd5;

  // Sequencer phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_OUT    = 3'd1;
  localparam logic [2:0] PH_IN     = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;
  localparam logic [2:0] PH_CANCEL = 3'd4;
  localparam logic [2:0] PH_FAIL   = 3'd5;

  // Curve shapes
  localparam logic [1:0] CV_SMOOTH = 2'd1;
  localparam logic [1:0] CV_SINE   = 2'd2;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [TIME_BITS-1:0]   delta_ticks;
    logic                   target_loaded;
    logic                   same_as_playing;
    logic                   nothing_playing;
    logic [VOLUME_BITS-1:0] music_volume;
    logic [TIME_BITS-1:0]   out_length;
    logic [TIME_BITS-1:0]   in_length;
    logic [1:0]             curve_kind;
    logic                   reject_if_busy;
  } tcf_in_t;

  typedef struct packed {
    logic [2:0]             action;
    logic [VOLUME_BITS-1:0] volume;
    logic [2:0]             phase_state;
    logic                   accepted;
    logic [GAIN_W-1:0]      overall_progress;
    logic                   last;
  } tcf_out_t;

  typedef struct packed {
    logic                 start;
    logic [TIME_BITS-1:0] num;
    logic [TIME_BITS-1:0] den;
  } tcf_div_req_t;

  typedef logic [GAIN_W-1:0] sine_tab_t [0:SINE_ENTRIES];

  // Quarter-sine table in Q1.16, by integer Taylor series, evaluated at elaboration
  function automatic sine_tab_t build_sine();
    sine_tab_t       t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          r;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      x    = (HALF_PI_Q30 * longint'(i)) / SINE_ENTRIES;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DEN[k];
        if ((k % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      r = (sum + 64'sd8192) / 64'sd16384;
      if (r < 0) r = 0;
      if (r > longint'(GAIN_ONE)) r = longint'(GAIN_ONE);
      t[i] = GAIN_W'(r);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

[rtl/tcf_div.sv]
// Restoring divider, one quotient bit per cycle: (num << 16) / den with num < den.
module tcf_div import tcf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcf_div_req_t         req_i,
  output logic                 done_o,
  output logic [GAIN_FRAC-1:0] quot_o
);

  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [TIME_BITS-1:0] den_r, den_nxt;
  logic [GAIN_FRAC-1:0] quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [TIME_BITS:0]   shifted;
  logic                 ge;

  // One shift-subtract step
  always_comb begin
    shifted  = {rem_r, 1'b0};
    ge       = shifted >= {1'b0, den_r};
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req_i.start) begin
      rem_nxt  = req_i.num;
      den_nxt  = req_i.den;
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? TIME_BITS'(shifted - {1'b0, den_r}) : TIME_BITS'(shifted);
      quo_nxt = {quo_r[GAIN_FRAC-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(GAIN_FRAC - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done_o = done_r;
  assign quot_o = quo_r;

endmodule

[rtl/two_phase_crossfade_envelope.sv]
// Two-phase crossfade sequencer: state machine around a shared multiplier and divider.
// Output: one item emits 1 to 10 transactions; a tick that reaches a volume step in a
// running phase waits on the bit-serial divider, and each result waits until the output
// register is free.
// Throughput: one item at a time; in_stall is high from acceptance until the last result
// of the item is loaded into the output register.
// Reset: synchronous active-low rst_n returns to idle with all held settings cleared.
module two_phase_crossfade_envelope import tcf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tcf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tcf_out_t out_data
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISP     = 5'd1;
  localparam logic [4:0] S_CAN_A    = 5'd2;
  localparam logic [4:0] S_CAN_B    = 5'd3;
  localparam logic [4:0] S_RST_Z    = 5'd4;
  localparam logic [4:0] S_ST_LOAD  = 5'd5;
  localparam logic [4:0] S_ST_NP    = 5'd6;
  localparam logic [4:0] S_ADV_CHK  = 5'd7;
  localparam logic [4:0] S_ADV_LOOP = 5'd8;
  localparam logic [4:0] S_ADV_P    = 5'd9;
  localparam logic [4:0] S_DIVW     = 5'd10;
  localparam logic [4:0] S_GAIN     = 5'd11;
  localparam logic [4:0] S_SM1      = 5'd12;
  localparam logic [4:0] S_SM2      = 5'd13;
  localparam logic [4:0] S_SIN1     = 5'd14;
  localparam logic [4:0] S_VOL      = 5'd15;
  localparam logic [4:0] S_VOLE     = 5'd16;
  localparam logic [4:0] S_ADV_DONE = 5'd17;
  localparam logic [4:0] S_ADV_PLAY = 5'd18;
  localparam logic [4:0] S_ADV_FI   = 5'd19;
  localparam logic [4:0] S_ADV_CMP  = 5'd20;
  localparam logic [4:0] S_EMIT     = 5'd21;

  logic [4:0]             state_r, state_nxt;
  tcf_in_t                in_q_r, in_q_nxt;
  logic [2:0]             phase_r, phase_nxt;
  logic [TIME_BITS-1:0]   elapsed_r, elapsed_nxt;
  logic [TIME_BITS-1:0]   out_len_r, out_len_nxt;
  logic [TIME_BITS-1:0]   in_len_r, in_len_nxt;
  logic [1:0]             curve_r, curve_nxt;
  logic [VOLUME_BITS-1:0] peak_r, peak_nxt;
  logic [TIME_BITS-1:0]   rem_r, rem_nxt;
  logic                   loaded_r, loaded_nxt;
  logic                   acc_r, acc_nxt;
  logic [GAIN_W-1:0]      p_r, p_nxt;
  logic [GAIN_W-1:0]      g_r, g_nxt;
  logic [GAIN_W-1:0]      sine_a_r, sine_a_nxt;
  logic [2*MUL_W-1:0]     prod_r, prod_nxt;
  logic [2:0]             emit_act_r, emit_act_nxt;
  logic [VOLUME_BITS-1:0] emit_vol_r, emit_vol_nxt;
  logic                   emit_last_r, emit_last_nxt;
  logic [4:0]             emit_ret_r, emit_ret_nxt;
  tcf_out_t               out_q_r, out_q_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [MUL_W-1:0]       mul_a, mul_b;
  tcf_div_req_t           div_req;
  logic                   div_done;
  logic [GAIN_FRAC-1:0]   div_quot;

  logic                   running, falling, emit_ok, accept;
  logic [TIME_BITS-1:0]   cur_len, need, used;
  logic [GAIN_W-1:0]      half, overall, q, s_val;
  logic [19:0]            s_full;
  logic [SINE_POS_W-1:0]  pos;
  logic [SINE_IDX_W-1:0]  idx;
  logic [GAIN_FRAC-1:0]   frac;
  logic [GAIN_W-1:0]      tab_a, tab_b, tab_d;
  logic [VOLUME_BITS-1:0] peak_sat;

  tcf_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Derived status
  always_comb begin
    running  = (phase_r == PH_OUT) || (phase_r == PH_IN);
    falling  = (phase_r == PH_OUT);
    cur_len  = falling ? out_len_r : in_len_r;
    need     = cur_len - elapsed_r;
    used     = (rem_r < need) ? rem_r : need;
    emit_ok  = !out_valid_r || !out_stall;
    accept   = in_valid && (state_r == S_IDLE);
    peak_sat = (in_q_r.music_volume > VOL_ONE) ? VOL_ONE : in_q_r.music_volume;
    // overall progress from current phase and cached fraction
    if (elapsed_r == '0) half = (cur_len == '0) ? GAIN_HALF : '0;
    else half = {1'b0, p_r[GAIN_W-1:1]};
    if (phase_r == PH_DONE) overall = GAIN_ONE;
    else if (running) overall = (falling ? '0 : GAIN_HALF) + half;
    else overall = '0;
    // quarter-sine lookup
    q      = (phase_r == PH_IN) ? p_r : GAIN_ONE - p_r;
    pos    = SINE_POS_W'(q) * SINE_POS_W'(SINE_ENTRIES);
    idx    = pos[GAIN_FRAC +: SINE_IDX_W];
    frac   = pos[GAIN_FRAC-1:0];
    tab_a  = SINE_TAB[idx];
    tab_b  = SINE_TAB[idx + 1'b1];
    tab_d  = (tab_b < tab_a) ? '0 : tab_b - tab_a;
    s_full = prod_r[2*MUL_W-1:GAIN_FRAC];
    s_val  = (s_full > 20'(GAIN_ONE)) ? GAIN_ONE : s_full[GAIN_W-1:0];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    in_q_nxt      = in_q_r;
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    out_len_nxt   = out_len_r;
    in_len_nxt    = in_len_r;
    curve_nxt     = curve_r;
    peak_nxt      = peak_r;
    rem_nxt       = rem_r;
    loaded_nxt    = loaded_r;
    acc_nxt       = acc_r;
    p_nxt         = p_r;
    g_nxt         = g_r;
    sine_a_nxt    = sine_a_r;
    emit_act_nxt  = emit_act_r;
    emit_vol_nxt  = emit_vol_r;
    emit_last_nxt = emit_last_r;
    emit_ret_nxt  = emit_ret_r;
    out_q_nxt     = out_q_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = elapsed_r;
    div_req.den   = cur_len;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          in_q_nxt  = in_data;
          acc_nxt   = 1'b0;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        state_nxt     = S_EMIT;
        emit_act_nxt  = ACT_NONE;
        emit_vol_nxt  = '0;
        emit_last_nxt = 1'b1;
        emit_ret_nxt  = S_IDLE;
        case (in_q_r.cmd)
          CMD_TICK: begin
            rem_nxt    = in_q_r.delta_ticks;
            loaded_nxt = in_q_r.target_loaded;
            state_nxt  = S_ADV_CHK;
          end
          CMD_START: begin
            if (!in_q_r.target_loaded) begin
              phase_nxt    = PH_FAIL;
              emit_act_nxt = ACT_STATE;
            end else if (running) begin
              if (!in_q_r.reject_if_busy) begin
                acc_nxt   = 1'b1;
                state_nxt = S_CAN_A;
              end
            end else begin
              acc_nxt   = 1'b1;
              state_nxt = S_ST_LOAD;
            end
          end
          CMD_CANCEL: begin
            if (running) state_nxt = S_CAN_A;
          end
          default: begin
            state_nxt = running ? S_CAN_A : S_RST_Z;
          end
        endcase
      end

      // Cancel: pin the running track at peak, then report
      S_CAN_A: begin
        emit_act_nxt  = falling ? ACT_SET_OUT : ACT_SET_IN;
        emit_vol_nxt  = peak_r;
        emit_last_nxt = 1'b0;
        emit_ret_nxt  = S_CAN_B;
        state_nxt     = S_EMIT;
      end

      S_CAN_B: begin
        phase_nxt     = PH_CANCEL;
        emit_act_nxt  = ACT_STATE;
        emit_vol_nxt  = '0;
        emit_last_nxt = (in_q_r.cmd == CMD_CANCEL);
        case (in_q_r.cmd)
          CMD_CANCEL: emit_ret_nxt = S_IDLE;
          CMD_START:  emit_ret_nxt = S_ST_LOAD;
          default:    emit_ret_nxt = S_RST_Z;
        endcase
        state_nxt = S_EMIT;
      end

      S_RST_Z: begin
        phase_nxt     = PH_IDLE;
        elapsed_nxt   = '0;
        emit_act_nxt  = ACT_NONE;
        emit_vol_nxt  = '0;
        emit_last_nxt = 1'b1;
        emit_ret_nxt  = S_IDLE;
        state_nxt     = S_EMIT;
      end

      // Take the new fade settings
      S_ST_LOAD: begin
        out_len_nxt   = in_q_r.out_length;
        in_len_nxt    = in_q_r.in_length;
        curve_nxt     = in_q_r.curve_kind;
        elapsed_nxt   = '0;
        peak_nxt      = peak_sat;
        emit_vol_nxt  = '0;
        emit_act_nxt  = ACT_STATE;
        state_nxt     = S_EMIT;
        if (in_q_r.same_as_playing) begin
          phase_nxt     = PH_DONE;
          emit_last_nxt = 1'b1;
          emit_ret_nxt  = S_IDLE;
        end else if (in_q_r.nothing_playing) begin
          emit_act_nxt  = ACT_PLAY_IN;
          emit_vol_nxt  = peak_sat;
          emit_last_nxt = 1'b0;
          emit_ret_nxt  = S_ST_NP;
        end else begin
          phase_nxt     = PH_OUT;
          rem_nxt       = '0;
          loaded_nxt    = 1'b1;
          emit_last_nxt = 1'b0;
          emit_ret_nxt  = S_ADV_CHK;
        end
      end

      S_ST_NP: begin
        phase_nxt     = PH_DONE;
        emit_act_nxt  = ACT_STATE;
        emit_vol_nxt  = '0;
        emit_last_nxt = 1'b1;
        emit_ret_nxt  = S_IDLE;
        state_nxt     = S_EMIT;
      end

      // Fail a running fade whose incoming track went away
      S_ADV_CHK: begin
        if (running && !loaded_r) begin
          phase_nxt     = PH_FAIL;
          emit_act_nxt  = ACT_STATE;
          emit_vol_nxt  = '0;
          emit_last_nxt = 1'b1;
          emit_ret_nxt  = S_IDLE;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_ADV_LOOP;
        end
      end

      // Spend ticks on the current phase
      S_ADV_LOOP: begin
        if (!running) begin
          emit_act_nxt  = ACT_NONE;
          emit_vol_nxt  = '0;
          emit_last_nxt = 1'b1;
          emit_ret_nxt  = S_IDLE;
          state_nxt     = S_EMIT;
        end else begin
          if (cur_len != '0) begin
            elapsed_nxt = elapsed_r + used;
            rem_nxt     = rem_r - used;
          end
          state_nxt = S_ADV_P;
        end
      end

      S_ADV_P: begin
        if ((cur_len == '0) || (elapsed_r >= cur_len)) begin
          p_nxt     = GAIN_ONE;
          state_nxt = S_GAIN;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIVW;
        end
      end

      S_DIVW: begin
        if (div_done) begin
          p_nxt     = GAIN_W'(div_quot);
          state_nxt = S_GAIN;
        end
      end

      // Shape the gain
      S_GAIN: begin
        if (curve_r == CV_SMOOTH) begin
          mul_a     = MUL_W'(p_r);
          mul_b     = MUL_W'(p_r);
          state_nxt = S_SM1;
        end else if (curve_r == CV_SINE) begin
          if (idx >= SINE_IDX_W'(SINE_ENTRIES)) begin
            g_nxt     = SINE_TAB[SINE_ENTRIES];
            state_nxt = S_VOL;
          end else begin
            sine_a_nxt = tab_a;
            mul_a      = MUL_W'(tab_d);
            mul_b      = MUL_W'(frac);
            state_nxt  = S_SIN1;
          end
        end else begin
          g_nxt     = (phase_r == PH_IN) ? p_r : GAIN_ONE - p_r;
          state_nxt = S_VOL;
        end
      end

      S_SM1: begin
        mul_a     = MUL_W'(prod_r[GAIN_FRAC +: GAIN_W]);
        mul_b     = SMOOTH_K - MUL_W'({p_r, 1'b0});
        state_nxt = S_SM2;
      end

      S_SM2: begin
        g_nxt     = (phase_r == PH_IN) ? s_val : GAIN_ONE - s_val;
        state_nxt = S_VOL;
      end

      S_SIN1: begin
        g_nxt     = sine_a_r + prod_r[GAIN_FRAC +: GAIN_W];
        state_nxt = S_VOL;
      end

      S_VOL: begin
        mul_a     = MUL_W'(peak_r);
        mul_b     = MUL_W'(g_r);
        state_nxt = S_VOLE;
      end

      S_VOLE: begin
        emit_act_nxt  = falling ? ACT_SET_OUT : ACT_SET_IN;
        emit_vol_nxt  = prod_r[GAIN_FRAC +: VOLUME_BITS];
        emit_last_nxt = (cur_len != '0) && (elapsed_r < cur_len);
        emit_ret_nxt  = emit_last_nxt ? S_IDLE : S_ADV_DONE;
        state_nxt     = S_EMIT;
      end

      // Phase finished: hand over to fade-in or complete
      S_ADV_DONE: begin
        elapsed_nxt   = '0;
        emit_last_nxt = 1'b0;
        state_nxt     = S_EMIT;
        if (falling) begin
          emit_act_nxt = ACT_STOP_OUT;
          emit_vol_nxt = '0;
          emit_ret_nxt = S_ADV_PLAY;
        end else begin
          emit_act_nxt = ACT_SET_IN;
          emit_vol_nxt = peak_r;
          emit_ret_nxt = S_ADV_CMP;
        end
      end

      S_ADV_PLAY: begin
        emit_act_nxt  = ACT_PLAY_IN;
        emit_vol_nxt  = '0;
        emit_last_nxt = 1'b0;
        emit_ret_nxt  = S_ADV_FI;
        state_nxt     = S_EMIT;
      end

      S_ADV_FI: begin
        phase_nxt     = PH_IN;
        emit_act_nxt  = ACT_STATE;
        emit_vol_nxt  = '0;
        emit_last_nxt = 1'b0;
        emit_ret_nxt  = S_ADV_LOOP;
        state_nxt     = S_EMIT;
      end

      S_ADV_CMP: begin
        phase_nxt     = PH_DONE;
        emit_act_nxt  = ACT_STATE;
        emit_vol_nxt  = '0;
        emit_last_nxt = 1'b1;
        emit_ret_nxt  = S_IDLE;
        state_nxt     = S_EMIT;
      end

      // Push one result transaction when the output register frees up
      S_EMIT: begin
        if (emit_ok) begin
          out_q_nxt.action           = emit_act_r;
          out_q_nxt.volume           = emit_vol_r;
          out_q_nxt.phase_state      = phase_r;
          out_q_nxt.accepted         = acc_r;
          out_q_nxt.overall_progress = overall;
          out_q_nxt.last             = emit_last_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = emit_ret_r;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    prod_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      elapsed_r   <= '0;
      out_len_r   <= '0;
      in_len_r    <= '0;
      curve_r     <= '0;
      peak_r      <= '0;
      p_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      out_len_r   <= out_len_nxt;
      in_len_r    <= in_len_nxt;
      curve_r     <= curve_nxt;
      peak_r      <= peak_nxt;
      p_r         <= p_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_q_r      <= in_q_nxt;
    rem_r       <= rem_nxt;
    loaded_r    <= loaded_nxt;
    acc_r       <= acc_nxt;
    g_r         <= g_nxt;
    sine_a_r    <= sine_a_nxt;
    prod_r      <= prod_nxt;
    emit_act_r  <= emit_act_nxt;
    emit_vol_r  <= emit_vol_nxt;
    emit_last_r <= emit_last_nxt;
    emit_ret_r  <= emit_ret_nxt;
    out_q_r     <= out_q_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

  // Elapsed time never runs past the active phase length
  a_elapsed_out: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_OUT) |-> (elapsed_r <= out_len_r))
    else $error("elapsed beyond fade-out length");

  a_elapsed_in: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IN) |-> (elapsed_r <= in_len_r))
    else $error("elapsed beyond fade-in length");

  // Divider results only arrive while the sequencer waits for them
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVW))
    else $error("divider finished outside its wait state");

  // The final result of an item returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && emit_ok && emit_last_r) |=> (state_r == S_IDLE))
    else $error("last result did not end the item");

  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_q_r.overall_progress <= GAIN_ONE))
    else $error("progress above unity");

endmodule
